[design/tbec_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the time-bucketed event counters.
// Used by every module of the block; depends on nothing.
package tbec_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int MIN_W  = 11;
    localparam int CNT_W  = 16;

    localparam int BUCKETS_DEF        = 48;
    localparam int BUCKET_SECONDS_DEF = 1800;
    localparam int SECONDS_PER_MINUTE = 60;

    localparam int DIV_STEP   = 4;
    localparam int DIV_ITER   = DATA_W / DIV_STEP;
    localparam int DIV_ITER_W = $clog2(DIV_ITER);

    typedef enum logic [OP_W-1:0] {
        OP_QUERY    = 3'd0,
        OP_BLOCKED  = 3'd1,
        OP_CACHE    = 3'd2,
        OP_FORWARD  = 3'd3,
        OP_FAILURE  = 3'd4,
        OP_HISTORY  = 3'd5,
        OP_TOTALS   = 3'd6,
        OP_UNUSED   = 3'd7
    } t_op;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_idx;
        logic cap_slot;
        logic cap_idx;
        logic mem_rd;
        logic his_addr;
        logic mem_wr;
        logic bump_blocked;
        logic his_load;
        logic his_next;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic his_last;
    } t_sts;

endpackage

[design/time_bucketed_event_counters_core.sv]
`timescale 1ns / 1ps
// Top level of the time-bucketed event counters: controller plus datapath.
// Depends on tbec_pkg, tbec_ctrl and tbec_dp.
//
// The block handles one item at a time. Cache hit, forwarded, failure and
// unused opcodes are done in the cycle in which they are taken. A totals
// read gives its single result in the cycle after the item is taken. Query
// and blocked events and history reads first find the time slot and then the
// bucket with the shared divider; an event then does a read-modify-write of
// its bucket. A history read then gives BUCKETS results, each read in turn
// from the bucket memory and held until the receiver takes it.
module time_bucketed_event_counters_core #(
    parameter int BUCKETS        = tbec_pkg::BUCKETS_DEF,
    parameter int BUCKET_SECONDS = tbec_pkg::BUCKET_SECONDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tbec_pkg::OP_W-1:0]   i_op,
    input  logic [tbec_pkg::DATA_W-1:0] i_now_seconds,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tbec_pkg::MIN_W-1:0]  o_minutes_ago,
    output logic [tbec_pkg::CNT_W-1:0]  o_bucket_total,
    output logic [tbec_pkg::CNT_W-1:0]  o_bucket_blocked,
    output logic [tbec_pkg::DATA_W-1:0] o_total_queries,
    output logic [tbec_pkg::DATA_W-1:0] o_blocked_count,
    output logic [tbec_pkg::DATA_W-1:0] o_cache_hit_count,
    output logic [tbec_pkg::DATA_W-1:0] o_forwarded_count,
    output logic [tbec_pkg::DATA_W-1:0] o_failure_count,
    output logic                        o_last
);

    tbec_pkg::t_cmd cmd;
    tbec_pkg::t_sts sts;

    tbec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tbec_dp #(
        .BUCKETS        (BUCKETS),
        .BUCKET_SECONDS (BUCKET_SECONDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_op),
        .i_now_seconds     (i_now_seconds),
        .o_minutes_ago     (o_minutes_ago),
        .o_bucket_total    (o_bucket_total),
        .o_bucket_blocked  (o_bucket_blocked),
        .o_total_queries   (o_total_queries),
        .o_blocked_count   (o_blocked_count),
        .o_cache_hit_count (o_cache_hit_count),
        .o_forwarded_count (o_forwarded_count),
        .o_failure_count   (o_failure_count),
        .o_last            (o_last)
    );

endmodule

[design/tbec_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, DIV_STEP quotient bits per cycle.
// Depends on tbec_pkg for the data width and the bits per step.
module tbec_div #(
    parameter int DVS_W = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tbec_pkg::DATA_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]            i_divisor,
    output logic                        o_done,
    output logic [tbec_pkg::DATA_W-1:0] o_quot,
    output logic [DVS_W-1:0]            o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [tbec_pkg::DIV_ITER_W-1:0] r_cnt;
    logic [tbec_pkg::DATA_W-1:0]    r_q;
    logic [DVS_W-1:0]               r_rem;
    logic [DVS_W-1:0]               r_dvs;
    logic [tbec_pkg::DATA_W-1:0]    n_q;
    logic [DVS_W-1:0]               n_rem;
    logic [DVS_W:0]                 v_wide;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        v_wide = '0;
        for (int s = 0; s < tbec_pkg::DIV_STEP; s++) begin
            v_wide = {n_rem, n_q[tbec_pkg::DATA_W-1]};
            n_q    = {n_q[tbec_pkg::DATA_W-2:0], 1'b0};
            if (v_wide >= {1'b0, r_dvs}) begin
                v_wide = v_wide - {1'b0, r_dvs};
                n_q[0] = 1'b1;
            end
            n_rem = v_wide[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tbec_pkg::DIV_ITER_W'(tbec_pkg::DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

[design/tbec_dp.sv]
`timescale 1ns / 1ps
// Datapath: lifetime counters, bucket memory, history walk and result register.
// Depends on tbec_pkg and instantiates tbec_div.
module tbec_dp #(
    parameter int BUCKETS        = tbec_pkg::BUCKETS_DEF,
    parameter int BUCKET_SECONDS = tbec_pkg::BUCKET_SECONDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tbec_pkg::t_cmd              i_cmd,
    output tbec_pkg::t_sts              o_sts,
    input  logic [tbec_pkg::OP_W-1:0]   i_op,
    input  logic [tbec_pkg::DATA_W-1:0] i_now_seconds,
    output logic [tbec_pkg::MIN_W-1:0]  o_minutes_ago,
    output logic [tbec_pkg::CNT_W-1:0]  o_bucket_total,
    output logic [tbec_pkg::CNT_W-1:0]  o_bucket_blocked,
    output logic [tbec_pkg::DATA_W-1:0] o_total_queries,
    output logic [tbec_pkg::DATA_W-1:0] o_blocked_count,
    output logic [tbec_pkg::DATA_W-1:0] o_cache_hit_count,
    output logic [tbec_pkg::DATA_W-1:0] o_forwarded_count,
    output logic [tbec_pkg::DATA_W-1:0] o_failure_count,
    output logic                        o_last
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam logic [63:0] MAX_SLOT = 64'hFFFF_FFFF / 64'(BUCKET_SECONDS);
    localparam int TAG_W = $clog2(MAX_SLOT + 64'd1);
    localparam int DVS_MAX = (BUCKET_SECONDS > BUCKETS) ? BUCKET_SECONDS : BUCKETS;
    localparam int DVS_W = $clog2(DVS_MAX + 1);
    localparam int MIN_STEP = BUCKET_SECONDS / tbec_pkg::SECONDS_PER_MINUTE;
    localparam int MIN_START = ((BUCKETS - 1) * MIN_STEP) % (2 ** tbec_pkg::MIN_W);
    localparam int CW = tbec_pkg::CNT_W;
    localparam int DW = tbec_pkg::DATA_W;

    logic [TAG_W-1:0] mem_tag [BUCKETS];
    logic [CW-1:0]    mem_qry [BUCKETS];
    logic [CW-1:0]    mem_blk [BUCKETS];
    logic [BUCKETS-1:0] r_vld;

    logic [TAG_W-1:0] r_rd_tag;
    logic [CW-1:0]    r_rd_qry;
    logic [CW-1:0]    r_rd_blk;
    logic             r_rd_vld;

    logic [TAG_W-1:0] r_slot;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_walk_idx;
    logic [IDX_W-1:0] r_walk_ago;
    logic [TAG_W-1:0] r_walk_slot;
    logic [tbec_pkg::MIN_W-1:0] r_walk_min;

    logic [DW-1:0] r_life_qry;
    logic [DW-1:0] r_life_blk;
    logic [DW-1:0] r_life_hit;
    logic [DW-1:0] r_life_fwd;
    logic [DW-1:0] r_life_fail;

    logic [tbec_pkg::MIN_W-1:0] r_out_min;
    logic [CW-1:0] r_out_btot;
    logic [CW-1:0] r_out_bblk;
    logic [DW-1:0] r_out_qry;
    logic [DW-1:0] r_out_blk;
    logic [DW-1:0] r_out_hit;
    logic [DW-1:0] r_out_fwd;
    logic [DW-1:0] r_out_fail;
    logic          r_out_last;

    logic             div_done;
    logic [DW-1:0]    div_quot;
    logic [DVS_W-1:0] div_rem;
    logic [DW-1:0]    div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [IDX_W-1:0] rem_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [TAG_W-1:0] eff_tag;
    logic [CW-1:0]    eff_qry;
    logic [CW-1:0]    eff_blk;
    logic             evt_hit;
    logic             his_hit;
    logic [CW-1:0]    wr_qry;
    logic [CW-1:0]    wr_blk;

    assign div_dividend = i_cmd.div_sel_idx ? div_quot : i_now_seconds;
    assign div_divisor  = i_cmd.div_sel_idx ? DVS_W'(BUCKETS) : DVS_W'(BUCKET_SECONDS);
    assign rem_idx      = div_rem[IDX_W-1:0];

    tbec_div #(
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign rd_addr = i_cmd.his_addr ? r_walk_idx : r_idx;
    assign eff_tag = r_rd_vld ? r_rd_tag : '0;
    assign eff_qry = r_rd_vld ? r_rd_qry : '0;
    assign eff_blk = r_rd_vld ? r_rd_blk : '0;
    assign evt_hit = (eff_tag == r_slot);
    assign his_hit = (r_slot >= TAG_W'(r_walk_ago)) && (eff_tag == r_walk_slot);

    always_comb begin
        wr_qry = evt_hit ? eff_qry : '0;
        wr_blk = evt_hit ? eff_blk : '0;
        if (i_cmd.bump_blocked) begin
            wr_blk = wr_blk + 1'b1;
        end else begin
            wr_qry = wr_qry + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_tag <= mem_tag[rd_addr];
            r_rd_qry <= mem_qry[rd_addr];
            r_rd_blk <= mem_blk[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (i_cmd.mem_wr) begin
            mem_tag[r_idx] <= r_slot;
            mem_qry[r_idx] <= wr_qry;
            mem_blk[r_idx] <= wr_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.mem_wr) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_slot) begin
            r_slot <= div_quot[TAG_W-1:0];
        end
        if (i_cmd.cap_idx) begin
            r_idx       <= rem_idx;
            r_walk_idx  <= (rem_idx == IDX_W'(BUCKETS - 1)) ? '0 : rem_idx + 1'b1;
            r_walk_ago  <= IDX_W'(BUCKETS - 1);
            r_walk_slot <= r_slot - TAG_W'(BUCKETS - 1);
            r_walk_min  <= tbec_pkg::MIN_W'(MIN_START);
        end else if (i_cmd.his_next) begin
            r_walk_idx  <= (r_walk_idx == IDX_W'(BUCKETS - 1)) ? '0 : r_walk_idx + 1'b1;
            r_walk_ago  <= r_walk_ago - 1'b1;
            r_walk_slot <= r_walk_slot + 1'b1;
            r_walk_min  <= r_walk_min - tbec_pkg::MIN_W'(MIN_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_qry  <= '0;
            r_life_blk  <= '0;
            r_life_hit  <= '0;
            r_life_fwd  <= '0;
            r_life_fail <= '0;
        end else if (i_cmd.accept) begin
            case (tbec_pkg::t_op'(i_op))
                tbec_pkg::OP_QUERY:   r_life_qry  <= r_life_qry + 1'b1;
                tbec_pkg::OP_BLOCKED: r_life_blk  <= r_life_blk + 1'b1;
                tbec_pkg::OP_CACHE:   r_life_hit  <= r_life_hit + 1'b1;
                tbec_pkg::OP_FORWARD: r_life_fwd  <= r_life_fwd + 1'b1;
                tbec_pkg::OP_FAILURE: r_life_fail <= r_life_fail + 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_op == tbec_pkg::OP_TOTALS)) begin
            r_out_min  <= '0;
            r_out_btot <= '0;
            r_out_bblk <= '0;
            r_out_qry  <= r_life_qry;
            r_out_blk  <= r_life_blk;
            r_out_hit  <= r_life_hit;
            r_out_fwd  <= r_life_fwd;
            r_out_fail <= r_life_fail;
            r_out_last <= 1'b1;
        end else if (i_cmd.his_load) begin
            r_out_min  <= r_walk_min;
            r_out_btot <= his_hit ? eff_qry : '0;
            r_out_bblk <= his_hit ? eff_blk : '0;
            r_out_qry  <= '0;
            r_out_blk  <= '0;
            r_out_hit  <= '0;
            r_out_fwd  <= '0;
            r_out_fail <= '0;
            r_out_last <= (r_walk_ago == '0);
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.his_last = (r_walk_ago == '0);

    assign o_minutes_ago     = r_out_min;
    assign o_bucket_total    = r_out_btot;
    assign o_bucket_blocked  = r_out_bblk;
    assign o_total_queries   = r_out_qry;
    assign o_blocked_count   = r_out_blk;
    assign o_cache_hit_count = r_out_hit;
    assign o_forwarded_count = r_out_fwd;
    assign o_failure_count   = r_out_fail;
    assign o_last            = r_out_last;

endmodule

[design/tbec_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences the datapath for each item.
// Depends on tbec_pkg for the opcodes and the command and status structs.
module tbec_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [tbec_pkg::OP_W-1:0] i_op,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tbec_pkg::t_cmd            o_cmd,
    input  tbec_pkg::t_sts            i_sts
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV_SLOT = 9'b000000010,
        S_DIV_IDX  = 9'b000000100,
        S_EVT_RD   = 9'b000001000,
        S_EVT_WR   = 9'b000010000,
        S_HIS_RD   = 9'b000100000,
        S_HIS_LD   = 9'b001000000,
        S_HIS_OUT  = 9'b010000000,
        S_TOT_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [tbec_pkg::OP_W-1:0] r_op;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (tbec_pkg::t_op'(i_op))
                        tbec_pkg::OP_QUERY, tbec_pkg::OP_BLOCKED, tbec_pkg::OP_HISTORY: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV_SLOT;
                        end
                        tbec_pkg::OP_TOTALS: begin
                            n_state = S_TOT_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV_SLOT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_slot    = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_idx = 1'b1;
                    n_state           = S_DIV_IDX;
                end
            end
            S_DIV_IDX: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_idx = 1'b1;
                    n_state = (r_op == tbec_pkg::OP_HISTORY) ? S_HIS_RD : S_EVT_RD;
                end
            end
            S_EVT_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_EVT_WR;
            end
            S_EVT_WR: begin
                o_cmd.mem_wr       = 1'b1;
                o_cmd.bump_blocked = (r_op == tbec_pkg::OP_BLOCKED);
                n_state            = S_IDLE;
            end
            S_HIS_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.his_addr = 1'b1;
                n_state        = S_HIS_LD;
            end
            S_HIS_LD: begin
                o_cmd.his_load = 1'b1;
                n_state        = S_HIS_OUT;
            end
            S_HIS_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.his_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.his_next = 1'b1;
                        n_state        = S_HIS_RD;
                    end
                end
            end
            S_TOT_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= tbec_pkg::OP_UNUSED;
        end else begin
            r_state <= n_state;
            if (o_cmd.accept) begin
                r_op <= i_op;
            end
        end
    end

endmodule
